[design/pn2d_pkg.sv]
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types, constants and the gradient sine table function of the 2-D
// gradient noise pipeline.
// ----------------------------------------------------------------------------
package pn2d_pkg;

	localparam int COORD_W            = 32;
	localparam int NOISE_W            = 19;
	localparam int FRAC_BITS_DEFAULT  = 16;
	localparam int ANGLE_BITS_DEFAULT = 10;

	localparam logic [NOISE_W-1:0] NOISE_MAX = '1;

	// hash multipliers
	localparam logic [31:0] HASH_M0 = 32'd3284157443;
	localparam logic [31:0] HASH_M1 = 32'd1911520717;
	localparam logic [31:0] HASH_M2 = 32'd2048419325;

	// pi in unsigned Q2.30
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [NOISE_W-1:0] noise_t;

	// sin(2*pi*r/2^angle_bits) for the first quadrant, frac_bits fraction bits;
	// evaluated at elaboration only. Term n is divided by (2n)(2n+1).
	function automatic longint unsigned sin_quad(input int unsigned r,
		input int unsigned frac_bits, input int unsigned angle_bits);
		longint unsigned theta;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		theta = (PI_Q30 * 64'(r) * 64'd2) >> angle_bits;
		x2    = (theta * theta) >> 30;
		term  = theta;
		sum   = longint'(theta);
		term  = ((term * x2) >> 30) / 64'd6;
		sum   = sum - longint'(term);
		term  = ((term * x2) >> 30) / 64'd20;
		sum   = sum + longint'(term);
		term  = ((term * x2) >> 30) / 64'd42;
		sum   = sum - longint'(term);
		term  = ((term * x2) >> 30) / 64'd72;
		sum   = sum + longint'(term);
		term  = ((term * x2) >> 30) / 64'd110;
		sum   = sum - longint'(term);
		term  = ((term * x2) >> 30) / 64'd156;
		sum   = sum + longint'(term);
		term  = ((term * x2) >> 30) / 64'd210;
		sum   = sum - longint'(term);
		if (sum < 0)
			sum = 0;
		return (longint'(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
	endfunction

endpackage

[design/pn2d_if.sv]
// ----------------------------------------------------------------------------
// pn2d_if
// Valid/ready channels of the noise block: sample points in, noise values out.
// ----------------------------------------------------------------------------
interface pn2d_in_if
	import pn2d_pkg::*;
	;
	logic   valid;
	logic   ready;
	coord_t x_coord;
	coord_t y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface pn2d_out_if
	import pn2d_pkg::*;
	;
	logic   valid;
	logic   ready;
	noise_t noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink   (input valid, input noise_value, output ready);
endinterface

[design/perlin_noise_2d.sv]
// ----------------------------------------------------------------------------
// perlin_noise_2d
// 2-D gradient noise of one signed fixed-point point per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   sample : sink channel, x_coord / y_coord signed, FRAC_BITS fraction bits.
//   noise  : source channel, noise_value = 10*|noise|, unsigned, saturated.
//   Every sample transaction yields exactly one noise transaction, in order.
// Timing:
//   Twelve register stages, s1 to s12, lie between sample and noise. One
//   point is taken every cycle while noise.ready is high; the rate is set
//   by the stage chain, each stage holding at most one 32x32 hash multiply
//   or one fixed-point multiply.
// Stalls:
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out and sample.ready stays high while noise.ready is
//   high. A held result keeps its value until taken.
// Reset:
//   arst_n clears all stage valid bits at once; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module perlin_noise_2d
	import pn2d_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
	parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	pn2d_in_if.sink    sample,
	pn2d_out_if.source noise
);

	localparam int F       = FRAC_BITS;
	localparam int A       = ANGLE_BITS;
	localparam int QUARTER = 1 << (A - 2);
	localparam int G_W     = F + 2;     // gradient, signed
	localparam int DX_W    = F + 1;     // offset, signed
	localparam int P_W     = 2 * F + 3; // dot partial product
	localparam int SM_W    = 2 * F + 4; // dot sum
	localparam int D_W     = F + 3;     // dot result
	localparam int DF_W    = F + 4;     // blend difference
	localparam int W_W     = F + 1;     // smooth weight, unsigned
	localparam int BP_W    = 2 * F + 6; // blend product
	localparam int B_W     = F + 4;     // blended value
	localparam int NSTG    = 12;

	localparam logic [SM_W-1:0] DOT_HALF   = SM_W'(1) << (F - 1);
	localparam logic [BP_W-1:0] BLEND_HALF = BP_W'(1) << (F - 1);

	// first-quadrant sine table
	logic [F:0] sin_lut [0:QUARTER];
	for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_sin
		assign sin_lut[gi] = (F+1)'(sin_quad(gi, F, A));
	end

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	// signed sine by angle index via quadrant symmetry
	function automatic logic signed [G_W-1:0] sin_at(input logic [A-1:0] k);
		logic [A-2:0]   r;
		logic [F:0]     mag;
		r = {1'b0, k[A-3:0]};
		if (k[A-2])
			r = (A-1)'(QUARTER) - r;
		mag = sin_lut[r];
		return k[A-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// ---------------- stage control ----------------
	logic [NSTG:1] vld_q;
	logic [NSTG:1] en;

	always_comb begin
		en[NSTG] = !vld_q[NSTG] || noise.ready;
		for (int i = NSTG - 1; i >= 1; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= sample.valid;
			for (int i = 2; i <= NSTG; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign sample.ready = en[1];

	// ---------------- datapath registers ----------------
	logic [31:0]                mx_s1, my_s1;
	logic [F-1:0]               fx_s2, fy_s2, fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fy_s5;
	logic [31:0]                cy0_s2, cy1_s2;
	logic [31:0]                ax0_s2, ax1_s2, ax0_s3, ax1_s3;
	logic [F-1:0]               w2x_s2, w2y_s2;
	logic [31:0]                b_s3 [4];
	logic [W_W-1:0]             sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5, sx_s6, sy_s6;
	logic [W_W-1:0]             sx_s7, sy_s7, sy_s8, sy_s9;
	logic [A-1:0]               k_s4 [4];
	logic signed [G_W-1:0]      gx_s5 [4];
	logic signed [G_W-1:0]      gy_s5 [4];
	logic signed [P_W-1:0]      px_s6 [4];
	logic signed [P_W-1:0]      py_s6 [4];
	logic signed [D_W-1:0]      dot_s7 [4];
	logic signed [D_W-1:0]      d0_s8, d2_s8;
	logic signed [BP_W-1:0]     bt_s8, bb_s8;
	logic signed [B_W-1:0]      top_s9, bot_s9, top_s10;
	logic signed [BP_W-1:0]     bv_s10;
	logic signed [B_W-1:0]      v_s11;
	noise_t                     out_s12;

	// combinational helpers
	logic [31:0]                cx0_c, cx1_c;
	logic [2*F-1:0]             sqx_c, sqy_c;
	logic [F+1:0]               tx_c, ty_c;
	logic [2*F+1:0]             smx_c, smy_c;
	logic [31:0]                a_c [4];
	logic [31:0]                y_c [4];
	logic [31:0]                h_c [4];
	logic signed [DX_W-1:0]     dx_c [4];
	logic signed [DX_W-1:0]     dy_c [4];
	logic signed [SM_W-1:0]     dsum_c [4];
	logic signed [SM_W-1:0]     dsh_c [4];
	logic signed [DF_W-1:0]     dt_c, db_c, dv_c;
	logic signed [BP_W-1:0]     rt_c, rb_c, rv_c;
	logic [B_W-1:0]             vmag_c;
	logic [31:0]                ten_c;

	// cell split, hash operands, smoothstep pieces, dot sums, blend rounding and output magnitude
	always_comb begin
		cx0_c = mx_s1 >> F;
		cx1_c = cx0_c + 32'd1;
		sqx_c = (2*F)'(mx_s1[F-1:0]) * (2*F)'(mx_s1[F-1:0]);
		sqy_c = (2*F)'(my_s1[F-1:0]) * (2*F)'(my_s1[F-1:0]);
		tx_c  = ((F+2)'(3) << F) - ((F+2)'(fx_s2) << 1);
		ty_c  = ((F+2)'(3) << F) - ((F+2)'(fy_s2) << 1);
		smx_c = (2*F+2)'(tx_c) * (2*F+2)'(w2x_s2);
		smy_c = (2*F+2)'(ty_c) * (2*F+2)'(w2y_s2);
		for (int c = 0; c < 4; c++) begin
			a_c[c] = c[0] ? ax1_s2 : ax0_s2;
			y_c[c] = c[1] ? cy1_s2 : cy0_s2;
			h_c[c] = (c[0] ? ax1_s3 : ax0_s3) ^ rot16(b_s3[c]);
			dx_c[c] = c[0] ? $signed({1'b0, fx_s5}) - $signed(DX_W'(1) << F)
			               : $signed({1'b0, fx_s5});
			dy_c[c] = c[1] ? $signed({1'b0, fy_s5}) - $signed(DX_W'(1) << F)
			               : $signed({1'b0, fy_s5});
			dsum_c[c] = SM_W'(px_s6[c]) + SM_W'(py_s6[c]) + $signed(DOT_HALF);
			dsh_c[c]  = dsum_c[c] >>> F;
		end
		dt_c = DF_W'(dot_s7[1]) - DF_W'(dot_s7[0]);
		db_c = DF_W'(dot_s7[3]) - DF_W'(dot_s7[2]);
		rt_c = (bt_s8 + $signed(BLEND_HALF)) >>> F;
		rb_c = (bb_s8 + $signed(BLEND_HALF)) >>> F;
		dv_c = DF_W'(bot_s9) - DF_W'(top_s9);
		rv_c = (bv_s10 + $signed(BLEND_HALF)) >>> F;
		vmag_c = v_s11[B_W-1] ? B_W'(-v_s11) : B_W'(v_s11);
		ten_c  = 32'(vmag_c) * 32'd10;
	end

	// stage registers
	always_ff @(posedge clk) begin
		// s1: coordinate magnitude
		if (en[1]) begin
			mx_s1 <= sample.x_coord[31] ? 32'(-sample.x_coord) : sample.x_coord;
			my_s1 <= sample.y_coord[31] ? 32'(-sample.y_coord) : sample.y_coord;
		end
		// s2: cell split, x hash multiply, weight square
		if (en[2]) begin
			fx_s2  <= mx_s1[F-1:0];
			fy_s2  <= my_s1[F-1:0];
			cy0_s2 <= my_s1 >> F;
			cy1_s2 <= (my_s1 >> F) + 32'd1;
			ax0_s2 <= cx0_c * HASH_M0;
			ax1_s2 <= cx1_c * HASH_M0;
			w2x_s2 <= sqx_c[2*F-1:F];
			w2y_s2 <= sqy_c[2*F-1:F];
		end
		// s3: second hash multiply, smooth weight
		if (en[3]) begin
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
			ax0_s3 <= ax0_s2;
			ax1_s3 <= ax1_s2;
			sx_s3  <= smx_c[2*F:F];
			sy_s3  <= smy_c[2*F:F];
			for (int c = 0; c < 4; c++)
				b_s3[c] <= (y_c[c] ^ rot16(a_c[c])) * HASH_M1;
		end
		// s4: third hash multiply, angle index
		if (en[4]) begin
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
			for (int c = 0; c < 4; c++)
				k_s4[c] <= A'(32'(h_c[c] * HASH_M2) >> (32 - A));
		end
		// s5: gradient lookup
		if (en[5]) begin
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
			for (int c = 0; c < 4; c++) begin
				gx_s5[c] <= sin_at(k_s4[c]);
				gy_s5[c] <= sin_at(k_s4[c] + A'(QUARTER));
			end
		end
		// s6: dot partial products
		if (en[6]) begin
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;
			for (int c = 0; c < 4; c++) begin
				px_s6[c] <= P_W'(dx_c[c]) * P_W'(gx_s5[c]);
				py_s6[c] <= P_W'(dy_c[c]) * P_W'(gy_s5[c]);
			end
		end
		// s7: dot sum and rounding
		if (en[7]) begin
			sx_s7 <= sx_s6;
			sy_s7 <= sy_s6;
			for (int c = 0; c < 4; c++)
				dot_s7[c] <= D_W'(dsh_c[c]);
		end
		// s8: x blend products
		if (en[8]) begin
			d0_s8 <= dot_s7[0];
			d2_s8 <= dot_s7[2];
			sy_s8 <= sy_s7;
			bt_s8 <= BP_W'(dt_c) * $signed({1'b0, sx_s7});
			bb_s8 <= BP_W'(db_c) * $signed({1'b0, sx_s7});
		end
		// s9: x blend sums
		if (en[9]) begin
			top_s9 <= B_W'(d0_s8) + B_W'(rt_c);
			bot_s9 <= B_W'(d2_s8) + B_W'(rb_c);
			sy_s9  <= sy_s8;
		end
		// s10: y blend product
		if (en[10]) begin
			top_s10 <= top_s9;
			bv_s10  <= BP_W'(dv_c) * $signed({1'b0, sy_s9});
		end
		// s11: y blend sum
		if (en[11])
			v_s11 <= top_s10 + B_W'(rv_c);
		// s12: magnitude times ten, saturated
		if (en[12])
			out_s12 <= (ten_c > 32'(NOISE_MAX)) ? NOISE_MAX : ten_c[NOISE_W-1:0];
	end

	assign noise.valid       = vld_q[NSTG];
	assign noise.noise_value = out_s12;

endmodule

[design/pn2d_chk.sv]
// ----------------------------------------------------------------------------
// pn2d_chk
// Port-level checks of the noise block, bound to its top level.
// ----------------------------------------------------------------------------
module pn2d_chk
	import pn2d_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input noise_t out_value
);

	// no result is shown while reset is held
	a_rst_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("noise valid during reset");

	// a free output never back-pressures the sample side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("sample stalled while noise side is free");

	// a pending result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("pending noise transaction changed");

	// a shown result carries known bits
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_value))
		else $error("noise value unknown");

	// an offered sample always sees a driven ready
	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_ready))
		else $error("sample ready unknown");

endmodule

bind perlin_noise_2d pn2d_chk u_pn2d_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (noise.valid),
	.out_ready (noise.ready),
	.out_value (noise.noise_value)
);

[sim/perlin_noise_2d_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perlin_noise_2d_tb
// Self-checking bench for the 2-D gradient noise block. Points go in on the
// sample channel in random bursts. Each accepted unlisted point goes through a
// local bit-exact fixed-point model. Expected noise is queued and compared in
// order with every noise transaction; the noise side stalls, partly at random.
// ----------------------------------------------------------------------------
module perlin_noise_2d_tb;
	import pn2d_pkg::*;

	localparam int FB        = FRAC_BITS_DEFAULT;
	localparam int AB        = ANGLE_BITS_DEFAULT;
	localparam int N_RANDOM  = 930;
	localparam int LIMIT     = 300000;
	localparam int HOLD_LEN  = 90;
	localparam int HOLD_AT   = 300;
	localparam int DRAIN_AT  = 600;
	localparam int TAIL      = 40;

	typedef struct {
		coord_t x;
		coord_t y;
		bit     known;
		noise_t val;
	} point_row_t;

	logic clk;
	logic arst_n;

	pn2d_in_if  smp ();
	pn2d_out_if nse ();

	perlin_noise_2d dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.noise  (nse)
	);

	noise_t     noise_q[$];
	int         errors    = 0;
	int         cycles    = 0;
	int         n_sent    = 0;
	bit         hold_req  = 0;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// ------------------------------------------------------------------
	// fixed-point noise model
	// ------------------------------------------------------------------

	// first-quadrant sine, Taylor to x^15 in Q2.30, rounded to FB bits
	function automatic longint quarter_sine(input int unsigned r);
		longint unsigned th, sq, tm;
		longint          acc;
		th  = (PI_Q30 * 64'(r) * 64'd2) >> AB;
		sq  = (th * th) >> 30;
		tm  = th;
		acc = longint'(th);
		for (int n = 1; n <= 7; n++) begin
			tm = ((tm * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc -= longint'(tm);
			else
				acc += longint'(tm);
		end
		if (acc < 0)
			acc = 0;
		return longint'(($unsigned(acc) + (64'd1 << (29 - FB))) >> (30 - FB));
	endfunction

	function automatic longint grad_sine(input logic [AB-1:0] k);
		logic [1:0]  quad;
		int unsigned r;
		longint      v;
		quad = k[AB-1:AB-2];
		r    = k[AB-3:0];
		if (quad[0])
			r = (1 << (AB - 2)) - r;
		v = quarter_sine(r);
		return quad[1] ? -v : v;
	endfunction

	// multiply-and-rotate corner hash, top AB bits
	function automatic logic [AB-1:0] corner_hash(input logic [31:0] cx, input logic [31:0] cy);
		logic [31:0] a, b;
		a = cx * HASH_M0;
		b = cy ^ {a[15:0], a[31:16]};
		b = b * HASH_M1;
		a = a ^ {b[15:0], b[31:16]};
		a = a * HASH_M2;
		return a[31:32-AB];
	endfunction

	function automatic longint round_shift(input longint v);
		return (v + (64'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic longint corner_grad_dot(input logic [31:0] cx, input logic [31:0] cy,
		input longint dx, input longint dy);
		logic [AB-1:0] k, kc;
		k  = corner_hash(cx, cy);
		kc = k + AB'(1 << (AB - 2));
		return round_shift(dx * grad_sine(k) + dy * grad_sine(kc));
	endfunction

	function automatic longint ease_weight(input longint w);
		longint w2;
		w2 = (w * w) >>> FB;
		return (((64'sd3 <<< FB) - 2 * w) * w2) >>> FB;
	endfunction

	function automatic longint mix_lerp(input longint a0, input longint a1, input longint s);
		return a0 + round_shift((a1 - a0) * s);
	endfunction

	function automatic noise_t predict_noise(input coord_t xc, input coord_t yc);
		logic [31:0] mx, my, x0, y0;
		longint      one, fx, fy, sx, sy, top, bot, v;
		one = 64'sd1 <<< FB;
		mx  = xc[31] ? (32'd0 - xc) : xc;
		my  = yc[31] ? (32'd0 - yc) : yc;
		x0  = mx >> FB;
		y0  = my >> FB;
		fx  = longint'(mx[FB-1:0]);
		fy  = longint'(my[FB-1:0]);
		sx  = ease_weight(fx);
		sy  = ease_weight(fy);
		top = mix_lerp(corner_grad_dot(x0, y0, fx, fy),
			corner_grad_dot(x0 + 32'd1, y0, fx - one, fy), sx);
		bot = mix_lerp(corner_grad_dot(x0, y0 + 32'd1, fx, fy - one),
			corner_grad_dot(x0 + 32'd1, y0 + 32'd1, fx - one, fy - one), sx);
		v = mix_lerp(top, bot, sy);
		if (v < 0)
			v = -v;
		v = v * 10;
		if (v > longint'(NOISE_MAX))
			v = longint'(NOISE_MAX);
		return noise_t'(v);
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	function automatic coord_t rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom;
		else if (sel < 8)
			return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		else
			return {16'($urandom_range(0, 32'hFFFF)), 16'h0000}
				+ coord_t'($urandom_range(0, 3)) - 32'd2;
	endfunction

	// directed points; integer points have zero noise
	point_row_t directed[] = '{
		'{32'h0000_0000, 32'h0000_0000, 1, '0},
		'{32'h0001_0000, 32'h0002_0000, 1, '0},
		'{32'h8000_0000, 32'h8000_0000, 1, '0},
		'{32'h7FFF_0000, 32'h8000_0000, 1, '0},
		'{32'hFFFF_0000, 32'h0001_0000, 1, '0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0},
		'{32'h8000_0001, 32'h8000_0001, 0, '0},
		'{32'hFFFF_FFFF, 32'h0000_0001, 0, '0},
		'{32'h0000_8000, 32'h0000_8000, 0, '0},
		'{32'hFFFF_8000, 32'h0000_8000, 0, '0},
		'{32'h0000_FFFF, 32'h0000_FFFF, 0, '0},
		'{32'h0003_4000, 32'hFFFB_C000, 0, '0},
		'{32'h1234_5678, 32'h9ABC_DEF0, 0, '0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 0, '0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 0, '0},
		'{32'h8000_FFFF, 32'h7FFF_0001, 0, '0},
		'{32'h0000_0001, 32'hFFFF_FFFF, 0, '0}
	};

	int burst_left = 0;

	// one sample transaction, with burst/gap idling ahead of it
	task automatic offer_point(input coord_t xv, input coord_t yv, input bit known,
		input noise_t val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			smp.valid  = 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		smp.valid   = 1'b1;
		smp.x_coord = xv;
		smp.y_coord = yv;
		do
			@(posedge clk);
		while (!smp.ready);
		noise_q.push_back(known ? val : predict_noise(xv, yv));
		n_sent++;
		@(negedge clk);
	endtask

	initial begin
		smp.valid   = 1'b0;
		smp.x_coord = '0;
		smp.y_coord = '0;
		arst_n      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			offer_point(directed[i].x, directed[i].y, directed[i].known, directed[i].val);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == HOLD_AT)
				hold_req = 1'b1;
			// let the pipeline drain completely once
			if (i == DRAIN_AT) begin
				smp.valid  = 1'b0;
				burst_left = 0;
				while (noise_q.size() != 0)
					@(negedge clk);
			end
			offer_point(rand_coord(), rand_coord(), 0, '0);
		end
		smp.valid = 1'b0;

		while (noise_q.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// noise-side stall pattern, plus one long hold-off
	initial begin
		int phase;
		nse.ready = 1'b0;
		phase     = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				nse.ready = 1'b0;
				repeat (HOLD_LEN - 1) @(negedge clk);
				continue;
			end
			phase = (phase + 1) % 200;
			if (phase < 50)
				nse.ready = 1'b1;
			else if (phase < 120)
				nse.ready = (phase % 5 != 2);
			else
				nse.ready = ($urandom_range(0, 9) < 6);
		end
	end

	// noise transaction check
	always @(posedge clk) begin
		if (arst_n && nse.valid && nse.ready) begin
			if (noise_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected noise transaction %0d", nse.noise_value);
			end else begin
				if (nse.noise_value !== noise_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: noise_value exp %0d got %0d", noise_q[0],
							nse.noise_value);
				end
				void'(noise_q.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

[perlin_noise_2d.f]
design/pn2d_pkg.sv
design/pn2d_if.sv
design/perlin_noise_2d.sv
design/pn2d_chk.sv
sim/perlin_noise_2d_tb.sv
